### sv/bmh_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
`timescale 1ns / 1ps

package bmh_pkg;

  // Default sizing of the queue
  localparam int unsigned CapacityDef = 64;
  localparam int unsigned KeyWidthDef = 32;

  // Fixed widths of the beat fields
  localparam int unsigned KeyFieldW   = 32;
  localparam int unsigned CountFieldW = 7;
  localparam int unsigned StatusW     = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } bmh_status_e;

  // Command broadcast along the row of cells
  typedef struct packed {
    logic ins;
    logic rem;
  } bmh_cmd_t;

endpackage

### sv/bmh_in_if.sv
// Request channel: operation code and key.
`timescale 1ns / 1ps

interface bmh_in_if;
  import bmh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [KeyFieldW-1:0] key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

### sv/bmh_out_if.sv
// Result channel: removed key, current minimum, count and status.
`timescale 1ns / 1ps

interface bmh_out_if;
  import bmh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KeyFieldW-1:0]   removed_key;
  logic [KeyFieldW-1:0]   min_key;
  logic [CountFieldW-1:0] entry_count;
  logic [StatusW-1:0]     status;

  modport source (output valid, output removed_key, output min_key,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input removed_key, input min_key,
                  input entry_count, input status, output ready);
endinterface

### sv/bmh_cell.sv
// One cell of the sorted key row: holds a key, shifts right on insert, left on remove.
`timescale 1ns / 1ps

module bmh_cell #(
  parameter int unsigned KEY_WIDTH = bmh_pkg::KeyWidthDef
) (
  input  logic                 clk_i,
  input  bmh_pkg::bmh_cmd_t    cmd_i,
  input  logic                 occ_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] prev_key_i,
  input  logic [KEY_WIDTH-1:0] next_key_i,
  output logic [KEY_WIDTH-1:0] key_o
);
  import bmh_pkg::*;

  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] key_d;
  logic                 own_le;
  logic                 prev_le;

  // Pick the new key: keep, take the inserted key, or take a neighbour's
  always_comb begin
    own_le  = (key_q <= key_i);
    prev_le = (prev_key_i <= key_i);
    key_d   = key_q;
    if (cmd_i.ins) begin
      if (!(occ_i && own_le)) begin
        key_d = prev_le ? key_i : prev_key_i;
      end
    end else if (cmd_i.rem) begin
      key_d = next_key_i;
    end
  end

  // Hold the key
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

### sv/binary_min_heap_priority_queue_unit.sv
// Top level of the min-priority queue: a sorted row of key cells and the result register.
//
//   channel | dir | fields                                     | handshake
//   in_i    | in  | opcode, key_in                             | valid/ready
//   out_o   | out | removed_key, min_key, entry_count, status  | valid/ready
//
// On each beat every cell compares the broadcast key with its
// own and its left neighbour's key and shifts in a single step.
// The result is registered; a new request is taken while the result register is
// empty or its beat is being taken in the same cycle.
// Reset clears the entry count and the result valid; the cells need no clearing.
// A stalled result holds off the request side.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY  = bmh_pkg::CapacityDef,
  parameter int unsigned KEY_WIDTH = bmh_pkg::KeyWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmh_in_if.sink    in_i,
  bmh_out_if.source out_o
);
  import bmh_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CAPACITY);

  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q;
  logic [KeyFieldW-1:0] removed_q, removed_d;
  logic [KeyFieldW-1:0] min_q, min_d;
  bmh_status_e          status_q, status_d;

  logic                 accept;
  logic                 is_empty;
  logic                 is_full;
  bmh_cmd_t             cmd;
  logic [KEY_WIDTH-1:0] key_w;
  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  occ;

  // Handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntMax);
  assign key_w    = KEY_WIDTH'(in_i.key_in);

  // Command for the row of cells
  always_comb begin
    cmd.ins = accept && (in_i.opcode == OP_INSERT) && !is_full;
    cmd.rem = accept && (in_i.opcode == OP_REMOVE) && !is_empty;
  end

  // Row of cells, sorted ascending from cell zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic [KEY_WIDTH-1:0] prev_key;
    logic [KEY_WIDTH-1:0] next_key;

    assign occ[i] = (Idx < count_q);

    if (i == 0) begin : g_head
      assign prev_key = '0;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    bmh_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (occ[i]),
      .key_i      (key_w),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .key_o      (cell_key[i])
    );
  end

  // Next count and result fields
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    min_d     = is_empty ? '0 : KeyFieldW'(cell_key[0]);
    status_d  = ST_OK;
    if (in_i.opcode == OP_INSERT) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
        if (is_empty || (key_w < cell_key[0])) begin
          min_d = KeyFieldW'(key_w);
        end
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d   = count_q - 1'b1;
        removed_d = KeyFieldW'(cell_key[0]);
        min_d     = (count_q > CntW'(1)) ? KeyFieldW'(cell_key[1]) : '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      min_q     <= min_d;
      status_q  <= status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.removed_key = removed_q;
  assign out_o.min_key     = min_q;
  assign out_o.entry_count = CountFieldW'(count_q);
  assign out_o.status      = status_q;

`ifndef SYNTHESIS
  // Count never runs past the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count above capacity");

  // Remove on an empty queue reports empty and leaves the count at zero
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.opcode == OP_REMOVE) && is_empty
    |=> out_valid_q && (status_q == ST_EMPTY) && (count_q == '0))
    else $error("remove on empty queue misreported");

  // Insert below capacity grows the count by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.opcode == OP_INSERT) && !is_full
    |=> (count_q == CntW'($past(count_q) + 1'b1)) && (status_q == ST_OK))
    else $error("insert did not grow the queue");

  // A waiting result blocks the request side
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("request taken while result stalled");
`endif

endmodule

### tb/tb_top.sv
// Self-checking bench for the min-heap queue: directed table, then phased random traffic.
`timescale 1ns / 1ps

module tb_top;
  import bmh_pkg::*;

  localparam int unsigned Cap          = CapacityDef;
  localparam int unsigned KeyW         = KeyWidthDef;
  localparam int unsigned RandomItems  = 1950;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned NumDirected  = 22;

  // One result beat as the queue reports it
  typedef struct packed {
    logic [KeyFieldW-1:0]   removed_key;
    logic [KeyFieldW-1:0]   min_key;
    logic [CountFieldW-1:0] entry_count;
    bmh_status_e            status;
  } heap_result_t;

  // One row of directed stimulus; typed rows carry their own expectation
  typedef struct packed {
    logic                 op;
    logic [KeyFieldW-1:0] key;
    logic                 typed;
    heap_result_t         want;
  } stim_row_t;

  // Traffic mix of a random phase
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_e;

  localparam stim_row_t DirectedTab [NumDirected] = '{
    '{OP_REMOVE, 32'hDEADBEEF, 1'b1, '{32'h0, 32'h0, 7'd0, ST_EMPTY}},
    '{OP_INSERT, 32'hFFFFFFFF, 1'b1, '{32'h0, 32'hFFFFFFFF, 7'd1, ST_OK}},
    '{OP_INSERT, 32'h00000000, 1'b1, '{32'h0, 32'h0, 7'd2, ST_OK}},
    '{OP_INSERT, 32'h80000000, 1'b0, '0},
    '{OP_INSERT, 32'h80000000, 1'b0, '0},
    '{OP_INSERT, 32'h00000001, 1'b0, '0},
    '{OP_INSERT, 32'h7FFFFFFF, 1'b0, '0},
    '{OP_INSERT, 32'h00000000, 1'b0, '0},
    '{OP_REMOVE, 32'h55555555, 1'b0, '0},
    '{OP_REMOVE, 32'hAAAAAAAA, 1'b0, '0},
    '{OP_REMOVE, 32'h00000000, 1'b0, '0},
    '{OP_REMOVE, 32'hFFFFFFFF, 1'b0, '0},
    '{OP_REMOVE, 32'h12345678, 1'b0, '0},
    '{OP_REMOVE, 32'h87654321, 1'b0, '0},
    '{OP_REMOVE, 32'h0F0F0F0F, 1'b1, '{32'hFFFFFFFF, 32'h0, 7'd0, ST_OK}},
    '{OP_REMOVE, 32'hF0F0F0F0, 1'b1, '{32'h0, 32'h0, 7'd0, ST_EMPTY}},
    '{OP_INSERT, 32'h00000009, 1'b1, '{32'h0, 32'h9, 7'd1, ST_OK}},
    '{OP_INSERT, 32'h00000009, 1'b0, '0},
    '{OP_INSERT, 32'h00000009, 1'b0, '0},
    '{OP_INSERT, 32'h00000002, 1'b0, '0},
    '{OP_REMOVE, 32'h00000000, 1'b0, '0},
    '{OP_REMOVE, 32'h00000000, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  bmh_in_if  req_if ();
  bmh_out_if rsp_if ();

  binary_min_heap_priority_queue_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Predictor state: own copy of the heap
  logic [KeyW-1:0] heap_mem [Cap];
  int unsigned     fill_lvl;
  int unsigned     peak_lvl;

  heap_result_t    pending_q [$];
  bit              calm;
  int unsigned     err_cnt;
  int unsigned     cycle_cnt;
  int unsigned     n_results;
  int unsigned     n_insert;
  int unsigned     n_remove;
  int unsigned     n_full;
  int unsigned     n_empty;

  // Apply one operation to the predicted heap and return the result it gives
  function automatic heap_result_t apply_heap_op(input logic op,
                                                 input logic [KeyFieldW-1:0] key);
    heap_result_t    res;
    int unsigned     pos;
    int unsigned     up;
    int unsigned     lt;
    int unsigned     rt;
    int unsigned     pick;
    logic [KeyW-1:0] tmp;
    res = '0;
    res.status = ST_OK;
    if (op == OP_INSERT) begin
      n_insert++;
      if (fill_lvl >= Cap) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        heap_mem[fill_lvl] = key[KeyW-1:0];
        fill_lvl++;
        pos = fill_lvl - 1;
        // sift up while the parent is strictly greater
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (heap_mem[up] > heap_mem[pos]) begin
            tmp           = heap_mem[up];
            heap_mem[up]  = heap_mem[pos];
            heap_mem[pos] = tmp;
            pos           = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      n_remove++;
      if (fill_lvl == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        res.removed_key = KeyFieldW'(heap_mem[0]);
        fill_lvl--;
        if (fill_lvl > 0) begin
          heap_mem[0] = heap_mem[fill_lvl];
          pos = 0;
          // sift down; equal children favour the right one
          while (pos < fill_lvl) begin
            lt   = 2 * pos + 1;
            rt   = 2 * pos + 2;
            pick = pos;
            if (rt < fill_lvl && heap_mem[pick] > heap_mem[rt]) pick = rt;
            if (lt < fill_lvl && heap_mem[pick] > heap_mem[lt]) pick = lt;
            if (pick == pos) break;
            tmp            = heap_mem[pick];
            heap_mem[pick] = heap_mem[pos];
            heap_mem[pos]  = tmp;
            pos            = pick;
          end
        end
      end
    end
    if (fill_lvl > peak_lvl) peak_lvl = fill_lvl;
    res.min_key     = (fill_lvl > 0) ? KeyFieldW'(heap_mem[0]) : '0;
    res.entry_count = CountFieldW'(fill_lvl);
    return res;
  endfunction

  // Draw a key, weighted towards extremes and duplicates
  function automatic logic [KeyFieldW-1:0] draw_key();
    logic [KeyFieldW-1:0] k;
    case ($urandom_range(0, 9))
      0:       k = '0;
      1:       k = '1;
      2, 3:    k = KeyFieldW'($urandom_range(0, 15));
      4:       k = 32'hFFFFFFF0 | KeyFieldW'($urandom_range(0, 15));
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [KeyFieldW-1:0] got,
                                 input logic [KeyFieldW-1:0] want);
    err_cnt++;
    $display("[%0t] result %0d: %s got %h, want %h", $time, n_results, what, got, want);
  endtask

  // Present one request beat after a random gap and log its expectation
  task automatic send_request(input logic op, input logic [KeyFieldW-1:0] key,
                              input logic typed, input heap_result_t want);
    int unsigned  gap;
    heap_result_t pred;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key_in <= key;
    do @(posedge clk); while (!req_if.ready);
    pred = apply_heap_op(op, key);
    if (typed) pred = want;
    // append the expectation at the tail of the queue
    pending_q = {pending_q, pred};
  endtask

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, compare each beat with the oldest expectation
  initial begin
    int unsigned  stall;
    heap_result_t want;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (pending_q.size() == 0) begin
        report_mismatch("beat with nothing pending, min_key", rsp_if.min_key, '0);
      end else begin
        want = pending_q.pop_front();
        if (rsp_if.removed_key !== want.removed_key)
          report_mismatch("removed_key", rsp_if.removed_key, want.removed_key);
        if (rsp_if.min_key !== want.min_key)
          report_mismatch("min_key", rsp_if.min_key, want.min_key);
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", KeyFieldW'(rsp_if.entry_count),
                          KeyFieldW'(want.entry_count));
        if (rsp_if.status !== want.status)
          report_mismatch("status", KeyFieldW'(rsp_if.status), KeyFieldW'(want.status));
      end
      n_results++;
    end
  end

  // Stimulus: reset, directed table, phased random traffic, drain
  initial begin
    int unsigned  sent;
    int unsigned  phase;
    int unsigned  len;
    int unsigned  ins_pct;
    traffic_mix_e mix;
    logic         op;

    rst_n         <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_INSERT;
    req_if.key_in <= '0;
    calm          = 1'b0;
    fill_lvl      = 0;
    peak_lvl      = 0;
    err_cnt       = 0;
    n_results     = 0;
    n_insert      = 0;
    n_remove      = 0;
    n_full        = 0;
    n_empty       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    for (int r = 0; r < NumDirected; r++) begin
      send_request(DirectedTab[r].op, DirectedTab[r].key, DirectedTab[r].typed,
                   DirectedTab[r].want);
    end

    // random phases: first overfill, then overdrain, then mixed
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (phase == 0) begin
        mix = MIX_FILL;
        len = Cap + 16;
      end else if (phase == 1) begin
        mix = MIX_DRAIN;
        len = Cap + 16;
      end else begin
        mix = traffic_mix_e'($urandom_range(0, 2));
        len = $urandom_range(20, 120);
      end
      case (mix)
        MIX_FILL:  ins_pct = (phase == 0) ? 100 : 85;
        MIX_DRAIN: ins_pct = (phase == 1) ? 0 : 15;
        default:   ins_pct = 50;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len && sent < RandomItems; i++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        send_request(op, draw_key(), 1'b0, '0);
        sent++;
      end
      phase++;
    end
    req_if.valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Ran %0d inserts (%0d refused when full) and %0d removes (%0d on empty).",
             n_insert, n_full, n_remove, n_empty);
    $display("Checked %0d result beats; peak fill %0d of %0d, %0d mismatches.",
             n_results, peak_lvl, Cap, err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
